// File: sv/pipc_pkg.sv
// Shared types and constants for the point-in-polygon crossing block.
`timescale 1ns / 1ps

package pipc_pkg;

	// coordinate format: signed two's complement, 8 fraction bits
	localparam int COORD_BITS = 24;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	// vertex count saturates at the smallest valid polygon
	localparam logic [1:0] MIN_VERTS = 2'd3;

	// edge queue between front and back
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = $clog2(QDEPTH);
	localparam int QCNT_BITS = $clog2(QDEPTH + 1);

	// operands of one edge test, already differenced
	typedef struct packed {
		logic                 en;    // edge is live and straddles the point's y
		logic                 f1;    // far end at or above the point's y
		logic [DIFF_BITS-1:0] dy1t;  // y1 - ty
		logic [DIFF_BITS-1:0] dx01;  // x0 - x1
		logic [DIFF_BITS-1:0] dx1t;  // x1 - tx
		logic [DIFF_BITS-1:0] dy01;  // y0 - y1
	} edge_t;

	// one classified vertex on its way to the back end
	typedef struct packed {
		logic  new_poly;  // parity restarts before this vertex
		logic  last;      // result goes out with this vertex
		logic  too_few;   // polygon closed with fewer than three vertices
		edge_t e1;        // previous vertex to this one
		edge_t e2;        // closing edge back to the first vertex
	} item_t;

	// back-end status seen by the top-level checks
	typedef struct packed {
		logic s1_valid;
		logic s1_last;
	} bk_status_t;

	// build the differenced operands for the edge (x0,y0) to (x1,y1)
	function automatic edge_t make_edge(
		input logic [COORD_BITS-1:0] x0,
		input logic [COORD_BITS-1:0] y0,
		input logic [COORD_BITS-1:0] x1,
		input logic [COORD_BITS-1:0] y1,
		input logic [COORD_BITS-1:0] tx,
		input logic [COORD_BITS-1:0] ty
	);
		edge_t e;
		logic  f0;
		e.f1   = $signed(y1) >= $signed(ty);
		f0     = $signed(y0) >= $signed(ty);
		e.en   = f0 ^ e.f1;
		e.dy1t = {y1[COORD_BITS-1], y1} - {ty[COORD_BITS-1], ty};
		e.dx01 = {x0[COORD_BITS-1], x0} - {x1[COORD_BITS-1], x1};
		e.dx1t = {x1[COORD_BITS-1], x1} - {tx[COORD_BITS-1], tx};
		e.dy01 = {y0[COORD_BITS-1], y0} - {y1[COORD_BITS-1], y1};
		return e;
	endfunction

endpackage

// File: sv/pipc_front.sv
// Front end: takes vertices, tracks polygon state, forms edge operands.
`timescale 1ns / 1ps

module pipc_front import pipc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  first_vertex,
	input  logic                  last_vertex,
	input  logic                  q_full,
	output logic                  push,
	output item_t                 push_item
);

	logic [COORD_BITS-1:0] start_x_q, start_y_q, prior_x_q, prior_y_q;
	logic [1:0]            seen_q;
	logic                  new_poly;
	logic [1:0]            cnt_next;
	logic [COORD_BITS-1:0] st_x, st_y;
	edge_t                 e1, e2;

	assign item_stall = q_full;
	assign push       = item_valid && !q_full;

	// classify the vertex against the open polygon
	always_comb begin
		new_poly = first_vertex || (seen_q == 2'd0);
		if (new_poly) begin
			cnt_next = 2'd1;
		end else if (seen_q == MIN_VERTS) begin
			cnt_next = MIN_VERTS;
		end else begin
			cnt_next = seen_q + 2'd1;
		end
		st_x = new_poly ? vertex_x : start_x_q;
		st_y = new_poly ? vertex_y : start_y_q;

		e1    = make_edge(prior_x_q, prior_y_q, vertex_x, vertex_y, point_x, point_y);
		e1.en = e1.en && !new_poly;
		e2    = make_edge(vertex_x, vertex_y, st_x, st_y, point_x, point_y);
		e2.en = e2.en && last_vertex;

		push_item.new_poly = new_poly;
		push_item.last     = last_vertex;
		push_item.too_few  = cnt_next != MIN_VERTS;
		push_item.e1       = e1;
		push_item.e2       = e2;
	end

	// polygon state, updated on every transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
			seen_q    <= 2'd0;
		end else if (push) begin
			start_x_q <= st_x;
			start_y_q <= st_y;
			prior_x_q <= vertex_x;
			prior_y_q <= vertex_y;
			seen_q    <= last_vertex ? 2'd0 : cnt_next;
		end
	end

endmodule

// File: sv/pipc_queue.sv
// Short queue of classified vertices between front and back end.
`timescale 1ns / 1ps

module pipc_queue import pipc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	output logic  q_valid,
	output item_t q_item,
	input  logic  pop
);

	item_t                entry_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full    = count_q == QCNT_BITS'(QDEPTH);
	assign q_valid = count_q != '0;
	assign q_item  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/pipc_back.sv
// Back end: edge products, crossing parity and the result register.
`timescale 1ns / 1ps

module pipc_back import pipc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_stall,
	output logic       inside_res,
	output logic       too_few,
	output bk_status_t status
);

	logic                 advance;
	logic                 valid_s1, new_s1, last_s1, few_s1;
	logic                 en1_s1, f1_1_s1, en2_s1, f1_2_s1;
	logic [PROD_BITS-1:0] l1_s1, r1_s1, l2_s1, r2_s1;
	logic                 parity_q, res_valid_q, inside_q, few_q;
	logic                 t1, t2, p_new;

	// whole back end holds while a result waits at a stalled receiver
	assign advance = !res_valid_q || !res_stall;
	assign pop     = advance && q_valid;

	assign res_valid       = res_valid_q;
	assign inside_res      = inside_q;
	assign too_few         = few_q;
	assign status.s1_valid = valid_s1;
	assign status.s1_last  = last_s1;

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= q_valid;
		end
	end

	// stage 1: four independent signed products
	always_ff @(posedge clk) begin
		if (pop) begin
			new_s1  <= q_item.new_poly;
			last_s1 <= q_item.last;
			few_s1  <= q_item.too_few;
			en1_s1  <= q_item.e1.en;
			f1_1_s1 <= q_item.e1.f1;
			en2_s1  <= q_item.e2.en;
			f1_2_s1 <= q_item.e2.f1;
			l1_s1   <= $signed(q_item.e1.dy1t) * $signed(q_item.e1.dx01);
			r1_s1   <= $signed(q_item.e1.dx1t) * $signed(q_item.e1.dy01);
			l2_s1   <= $signed(q_item.e2.dy1t) * $signed(q_item.e2.dx01);
			r2_s1   <= $signed(q_item.e2.dx1t) * $signed(q_item.e2.dy01);
		end
	end

	// compare products and fold both crossings into the parity
	always_comb begin
		t1    = en1_s1 && (($signed(l1_s1) >= $signed(r1_s1)) == f1_1_s1);
		t2    = en2_s1 && (($signed(l2_s1) >= $signed(r2_s1)) == f1_2_s1);
		p_new = (parity_q && !new_s1) ^ t1 ^ t2;
	end

	// parity and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			res_valid_q <= 1'b0;
			inside_q    <= 1'b0;
			few_q       <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1 && last_s1;
			if (valid_s1) begin
				parity_q <= last_s1 ? 1'b0 : p_new;
				if (last_s1) begin
					inside_q <= p_new && !few_s1;
					few_q    <= few_s1;
				end
			end
		end
	end

endmodule

// File: sv/point_in_polygon_crossing.sv
// Top level of the streaming crossing-parity point-in-polygon test.
//
// Usage: one vertex per transfer on the item channel (item_valid/item_stall),
// each carrying the query point, the vertex and first/last marks. A polygon
// is a run of vertices closed by last_vertex; a result (inside_res, too_few)
// is sent on the res channel (res_valid/res_stall) only for the last vertex.
// Throughput: one vertex per cycle until a stall on res backs up the queue. A
// vertex passes the four-entry edge queue, then one product stage, and its
// result is presented in an output register.
// Front end (vertex classification and edge differences) and back end
// (products, compare, parity) are decoupled by the queue: a stall on res
// freezes the back end only, and item_stall rises once the queue is full.
// Fewer than three vertices gives too_few = 1 and inside_res = 0.
// Reset (arst_n low) empties the queue and the pipeline, closes any open
// polygon and clears the parity; no result is pending afterwards.
`timescale 1ns / 1ps

module point_in_polygon_crossing import pipc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [COORD_BITS-1:0] vertex_x,
	input  logic [COORD_BITS-1:0] vertex_y,
	input  logic                  first_vertex,
	input  logic                  last_vertex,
	output logic                  res_valid,
	input  logic                  res_stall,
	output logic                  inside_res,
	output logic                  too_few
);

	logic       push, q_full, q_valid, pop;
	item_t      push_item, q_item;
	bk_status_t bk_status;

	pipc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	pipc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop)
	);

	pipc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.inside_res (inside_res),
		.too_few    (too_few),
		.status     (bk_status)
	);

	// a short polygon never reports inside
	a_few_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(inside_res && too_few))
		else $error("inside reported for a polygon with too few vertices");

	// a new result comes only from a last vertex leaving the product stage
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(bk_status.s1_valid && bk_status.s1_last))
		else $error("result appeared without a last vertex in the back end");

	// the back end never pops an empty queue
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty edge queue");

	// the queue refuses vertices only when full, and then pushes nothing
	a_stall_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> !push)
		else $error("vertex pushed while item channel stalled");

endmodule

// File: test/tb_point_in_polygon_crossing.sv
// Self-checking testbench for the streaming crossing-parity point-in-polygon block.
`timescale 1ns / 1ps

module tb_point_in_polygon_crossing;
	import pipc_pkg::*;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// one polygon vertex as offered on the item channel
	typedef struct {
		coord_t px;
		coord_t py;
		coord_t vx;
		coord_t vy;
		bit     first_mark;
		bit     last_mark;
	} vertex_t;

	// one verdict as returned on the res channel
	typedef struct {
		bit in_poly;
		bit few_verts;
	} verdict_t;

	localparam coord_t MAXC         = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t MINC         = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam int     ITEMS        = 850;
	localparam int     MAX_GAP      = 18;
	localparam int     LONG_HOLD    = 400;
	localparam int     DRAIN_CYCLES = 20;
	localparam int     LIMIT        = 200000;

	logic   clk          = 1'b0;
	logic   arst_n       = 1'b0;
	logic   item_valid   = 1'b0;
	logic   item_stall;
	coord_t point_x      = '0;
	coord_t point_y      = '0;
	coord_t vertex_x     = '0;
	coord_t vertex_y     = '0;
	logic   first_vertex = 1'b0;
	logic   last_vertex  = 1'b0;
	logic   res_valid;
	logic   res_stall    = 1'b0;
	logic   inside_res;
	logic   too_few;

	point_in_polygon_crossing dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.vertex_x     (vertex_x),
		.vertex_y     (vertex_y),
		.first_vertex (first_vertex),
		.last_vertex  (last_vertex),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.inside_res   (inside_res),
		.too_few      (too_few)
	);

	always #5 clk = ~clk;

	vertex_t  pending_verts[$];
	verdict_t expected_verdicts[$];

	// shadow of the polygon tracking state
	coord_t poly_start_x = '0;
	coord_t poly_start_y = '0;
	coord_t prev_x       = '0;
	coord_t prev_y       = '0;
	int     vert_count   = 0;
	bit     crossing     = 1'b0;

	// transfer flags, registered at the rising edge
	bit item_taken = 1'b0;
	bit res_taken  = 1'b0;

	// sender and receiver pacing
	int gap_left    = 0;
	bit sender_busy = 1'b1;
	int sent_count  = 0;
	int wait_left   = 0;
	int hold_left   = 0;
	bit recv_busy   = 1'b1;

	// bookkeeping
	int errors        = 0;
	int vertices_seen = 0;
	int verdicts_seen = 0;
	int few_seen      = 0;
	int inside_seen   = 0;
	int cycle_count   = 0;

	// does the edge (x0,y0)-(x1,y1) flip the crossing parity for point (tx,ty)
	function automatic bit edge_flips(input coord_t x0, input coord_t y0,
		input coord_t x1, input coord_t y1, input coord_t tx, input coord_t ty);
		longint lhs;
		longint rhs;
		bit     above0;
		bit     above1;
		above0 = (y0 >= ty);
		above1 = (y1 >= ty);
		lhs = (longint'(y1) - longint'(ty)) * (longint'(x0) - longint'(x1));
		rhs = (longint'(x1) - longint'(tx)) * (longint'(y0) - longint'(y1));
		return (above0 != above1) && ((lhs >= rhs) == above1);
	endfunction

	// advance the polygon state by one vertex; queue a verdict on the last one
	task automatic track_vertex(input vertex_t v);
		if (v.first_mark || vert_count == 0) begin
			poly_start_x = v.vx;
			poly_start_y = v.vy;
			vert_count   = 1;
			crossing     = 1'b0;
		end else begin
			crossing ^= edge_flips(prev_x, prev_y, v.vx, v.vy, v.px, v.py);
			if (vert_count < 3)
				vert_count++;
		end
		prev_x = v.vx;
		prev_y = v.vy;
		if (v.last_mark) begin
			// closing edge uses the point of the last vertex
			crossing ^= edge_flips(v.vx, v.vy, poly_start_x, poly_start_y, v.px, v.py);
			if (vert_count < 3)
				expected_verdicts.insert(expected_verdicts.size(),
					verdict_t'{1'b0, 1'b1});
			else
				expected_verdicts.insert(expected_verdicts.size(),
					verdict_t'{crossing, 1'b0});
			vert_count = 0;
			crossing   = 1'b0;
		end
	endtask

	task automatic add_vertex(input coord_t px, input coord_t py, input coord_t vx,
		input coord_t vy, input bit fm, input bit lm);
		pending_verts.insert(pending_verts.size(), vertex_t'{px, py, vx, vy, fm, lm});
	endtask

	function automatic coord_t jitter(input coord_t c, input int span);
		return coord_t'(int'(c) + int'($urandom_range(0, 2 * span)) - span);
	endfunction

	// coordinate near a center: full range, tight, on a 1.0 grid, or wide
	function automatic coord_t pick_coord(input int style, input coord_t c);
		case (style)
			0: begin
				return coord_t'($urandom());
			end
			1: begin
				return jitter(c, 1 << 10);
			end
			2: begin
				return coord_t'(int'(c) + 256 * (int'($urandom_range(0, 8)) - 4));
			end
			default: begin
				return jitter(c, 1 << 20);
			end
		endcase
	endfunction

	// random polygon, mostly well formed, sometimes with broken marks
	task automatic queue_polygon();
		int     n;
		int     style;
		int     flaw;
		bit     roving;
		bit     fm;
		bit     lm;
		coord_t cx;
		coord_t cy;
		coord_t px;
		coord_t py;
		n      = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
		style  = $urandom_range(0, 3);
		flaw   = $urandom_range(0, 9);
		roving = ($urandom_range(0, 9) == 0);
		cx     = coord_t'($urandom());
		cy     = coord_t'($urandom());
		px     = pick_coord(style, cx);
		py     = pick_coord(style, cy);
		for (int k = 0; k < n; k++) begin
			if (roving) begin
				px = pick_coord(style, cx);
				py = pick_coord(style, cy);
			end
			// flaw 0 drops the first mark, flaw 1 the last, flaw 2 scrambles both
			fm = (k == 0) && (flaw != 0);
			lm = (k == n - 1) && (flaw != 1);
			if (flaw == 2) begin
				fm = bit'($urandom_range(0, 1));
				lm = bit'($urandom_range(0, 1));
			end
			add_vertex(px, py, pick_coord(style, cx), pick_coord(style, cy), fm, lm);
		end
	endtask

	// sender: offer pending vertices with random gaps, payload held while stalled
	always @(negedge clk) begin
		if (item_valid && !item_taken) begin
			// waiting for the transfer
		end else if (gap_left > 0) begin
			item_valid <= 1'b0;
			gap_left--;
		end else if (pending_verts.size() != 0) begin
			point_x      <= pending_verts[0].px;
			point_y      <= pending_verts[0].py;
			vertex_x     <= pending_verts[0].vx;
			vertex_y     <= pending_verts[0].vy;
			first_vertex <= pending_verts[0].first_mark;
			last_vertex  <= pending_verts[0].last_mark;
			item_valid   <= 1'b1;
			void'(pending_verts.pop_front());
			if (sent_count % 40 == 0)
				sender_busy = ($urandom_range(0, 2) != 0);
			gap_left = sender_busy ? $urandom_range(0, MAX_GAP) : 0;
			sent_count++;
		end else begin
			item_valid <= 1'b0;
		end
	end

	// receiver: random stall per verdict, plus two long hold-offs to back up the block
	always @(negedge clk) begin
		if (res_taken) begin
			if (verdicts_seen == 12 || verdicts_seen == 90)
				hold_left = LONG_HOLD;
			if (verdicts_seen % 16 == 0)
				recv_busy = ($urandom_range(0, 2) != 0);
			wait_left = recv_busy ? $urandom_range(0, MAX_GAP) : 0;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else if (wait_left > 0) begin
			res_stall <= 1'b1;
			wait_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// monitor: predict on each vertex transfer, check each verdict transfer
	always @(posedge clk) begin : monitor
		verdict_t want;
		item_taken <= item_valid && !item_stall;
		res_taken  <= res_valid && !res_stall;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				verdicts_seen++;
				few_seen    += too_few;
				inside_seen += inside_res;
				if (expected_verdicts.size() == 0) begin
					$error("unexpected verdict: inside_res=%0b too_few=%0b",
						inside_res, too_few);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					if (inside_res !== want.in_poly) begin
						$error("inside_res: expected %0b, got %0b", want.in_poly, inside_res);
						errors++;
					end
					if (too_few !== want.few_verts) begin
						$error("too_few: expected %0b, got %0b", want.few_verts, too_few);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				vertices_seen++;
				track_vertex('{point_x, point_y, vertex_x, vertex_y,
					first_vertex, last_vertex});
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding",
				cycle_count, expected_verdicts.size());
			$display("[point_in_polygon_crossing] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// single vertex, then two vertices: both too few
		add_vertex(0, 0, 100, 100, 1, 1);
		add_vertex(0, 0, -256, -256, 1, 0);
		add_vertex(0, 0, 256, 256, 0, 1);
		// unit triangle around the origin
		add_vertex(0, 0, -256, -256, 1, 0);
		add_vertex(0, 0, 256, -256, 0, 0);
		add_vertex(0, 0, 0, 256, 0, 1);
		// full-scale triangle, point at the origin and then at y = MAXC with x moving from MAXC to MINC
		add_vertex(0, 0, MINC, MINC, 1, 0);
		add_vertex(0, 0, MAXC, MINC, 0, 0);
		add_vertex(0, 0, 0, MAXC, 0, 1);
		add_vertex(MAXC, MAXC, MINC, MINC, 1, 0);
		add_vertex(MAXC, MAXC, MAXC, MINC, 0, 0);
		add_vertex(MINC, MAXC, 0, MAXC, 0, 1);
		// square with no first mark after a closed polygon
		add_vertex(0, 0, -512, -512, 0, 0);
		add_vertex(0, 0, 512, -512, 0, 0);
		add_vertex(0, 0, 512, 512, 0, 0);
		add_vertex(0, 0, -512, 512, 0, 1);
		// open polygon abandoned by a new first mark
		add_vertex(0, 0, 1000, 1000, 1, 0);
		add_vertex(0, 0, 2000, 1000, 0, 0);
		add_vertex(0, 0, -256, -256, 1, 0);
		add_vertex(0, 0, 256, -256, 0, 0);
		add_vertex(0, 0, 0, 256, 0, 1);
		// point moves between vertices; point y on vertex y
		add_vertex(0, 0, -256, -256, 1, 0);
		add_vertex(1000, 0, 256, -256, 0, 0);
		add_vertex(0, -256, 0, 256, 0, 1);

		while (pending_verts.size() < ITEMS)
			queue_polygon();

		while (pending_verts.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d vertices and %0d verdicts (%0d inside, %0d too few)",
			vertices_seen, verdicts_seen, inside_seen, few_seen);
		$display("with random sender gaps, receiver stalls and two long hold-offs");
		if (errors == 0)
			$display("[point_in_polygon_crossing] OK");
		else
			$display("[point_in_polygon_crossing] ERROR");
		$finish;
	end

endmodule
